// ----- rtl/core/pllpi_pkg.sv -----
package pllpi_pkg;

  // Default fixed-point formats: data Q16.16, coefficients Q1.30
  localparam int DEF_DATA_WIDTH     = 32;
  localparam int DEF_COEF_FRAC_BITS = 30;
  localparam int COEF_WIDTH         = 32;
  localparam int FIELD_WIDTH        = 32;

  // Coefficient products are clamped to +-2^PROD_LIM_EXP
  localparam int PROD_LIM_EXP  = 61;
  localparam int MUL_RES_WIDTH = PROD_LIM_EXP + 2;

  // Register port
  localparam int APB_ADDR_WIDTH  = 5;
  localparam int APB_DATA_WIDTH  = 32;
  localparam int REG_INDEX_WIDTH = APB_ADDR_WIDTH - 2;

  localparam logic [REG_INDEX_WIDTH-1:0] REG_PI_GAIN_NOW      = 3'd0;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_PI_GAIN_LAST     = 3'd1;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_LOWPASS_FEED     = 3'd2;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_LOWPASS_FEEDBACK = 3'd3;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_HALF_PERIOD      = 3'd4;

  // Reset values: Kp 0.8, Ki 1.2, T 1 ms, Wc 1 rad/s
  localparam logic signed [COEF_WIDTH-1:0] RST_PI_GAIN_NOW      = 32'sd859637704;
  localparam logic signed [COEF_WIDTH-1:0] RST_PI_GAIN_LAST     = -32'sd858349214;
  localparam logic signed [COEF_WIDTH-1:0] RST_LOWPASS_FEED     = 32'sd536603;
  localparam logic signed [COEF_WIDTH-1:0] RST_LOWPASS_FEEDBACK = 32'sd1072668618;
  localparam logic signed [COEF_WIDTH-1:0] RST_HALF_PERIOD      = 32'sd536871;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] pi_gain_now;
    logic signed [COEF_WIDTH-1:0] pi_gain_last;
    logic signed [COEF_WIDTH-1:0] lowpass_feed;
    logic signed [COEF_WIDTH-1:0] lowpass_feedback;
    logic signed [COEF_WIDTH-1:0] half_period;
  } pllpi_coef_t;

endpackage

// ----- rtl/core/pllpi_ref_if.sv -----
interface pllpi_ref_if;
  import pllpi_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [FIELD_WIDTH-1:0] reference_angle;

  modport source (output valid, output reference_angle, input ready);
  modport sink   (input valid, input reference_angle, output ready);

endinterface

// ----- rtl/core/pllpi_est_if.sv -----
interface pllpi_est_if;
  import pllpi_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [FIELD_WIDTH-1:0] speed_estimate;
  logic signed [FIELD_WIDTH-1:0] angle_estimate;

  modport source (output valid, output speed_estimate, output angle_estimate, input ready);
  modport sink   (input valid, input speed_estimate, input angle_estimate, output ready);

endinterface

// ----- rtl/core/pllpi_regs.sv -----
module pllpi_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pllpi_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [pllpi_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [pllpi_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                                 pready,
  output pllpi_pkg::pllpi_coef_t               coef
);
  import pllpi_pkg::*;

  logic [REG_INDEX_WIDTH-1:0] index;
  logic                       wr_en;

  assign pready = 1'b1;
  assign index  = paddr[APB_ADDR_WIDTH-1:2];
  assign wr_en  = psel & penable & pwrite & pready;

  // Write the addressed coefficient; drop writes beyond the map
  always_ff @(posedge clk) begin
    if (rst) begin
      coef.pi_gain_now      <= RST_PI_GAIN_NOW;
      coef.pi_gain_last     <= RST_PI_GAIN_LAST;
      coef.lowpass_feed     <= RST_LOWPASS_FEED;
      coef.lowpass_feedback <= RST_LOWPASS_FEEDBACK;
      coef.half_period      <= RST_HALF_PERIOD;
    end else if (wr_en) begin
      unique case (index)
        REG_PI_GAIN_NOW:      coef.pi_gain_now      <= $signed(pwdata[COEF_WIDTH-1:0]);
        REG_PI_GAIN_LAST:     coef.pi_gain_last     <= $signed(pwdata[COEF_WIDTH-1:0]);
        REG_LOWPASS_FEED:     coef.lowpass_feed     <= $signed(pwdata[COEF_WIDTH-1:0]);
        REG_LOWPASS_FEEDBACK: coef.lowpass_feedback <= $signed(pwdata[COEF_WIDTH-1:0]);
        REG_HALF_PERIOD:      coef.half_period      <= $signed(pwdata[COEF_WIDTH-1:0]);
        default: ;
      endcase
    end
  end

  // Read back the addressed coefficient
  always_comb begin
    unique case (index)
      REG_PI_GAIN_NOW:      prdata = APB_DATA_WIDTH'(coef.pi_gain_now);
      REG_PI_GAIN_LAST:     prdata = APB_DATA_WIDTH'(coef.pi_gain_last);
      REG_LOWPASS_FEED:     prdata = APB_DATA_WIDTH'(coef.lowpass_feed);
      REG_LOWPASS_FEEDBACK: prdata = APB_DATA_WIDTH'(coef.lowpass_feedback);
      REG_HALF_PERIOD:      prdata = APB_DATA_WIDTH'(coef.half_period);
      default:              prdata = '0;
    endcase
  end

endmodule

// ----- rtl/core/pllpi_serial_mul.sv -----
module pllpi_serial_mul #(
  parameter int A_WIDTH   = pllpi_pkg::DEF_DATA_WIDTH + 1,
  parameter int C_WIDTH   = pllpi_pkg::COEF_WIDTH,
  parameter int FRAC_BITS = pllpi_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       start,
  input  logic signed [A_WIDTH-1:0]                  a,
  input  logic signed [C_WIDTH-1:0]                  c,
  output logic                                       done,
  output logic signed [pllpi_pkg::MUL_RES_WIDTH-1:0] product
);
  import pllpi_pkg::*;

  localparam int RW    = MUL_RES_WIDTH;
  localparam int PW    = A_WIDTH + C_WIDTH;
  localparam int QW    = PW - FRAC_BITS;
  localparam int QXW   = (QW > RW) ? QW : RW;
  localparam int CNT_W = $clog2(A_WIDTH);

  localparam logic [CNT_W-1:0]     LAST_STEP = CNT_W'(A_WIDTH - 1);
  localparam logic [QXW-1:0]       LIM_X     = QXW'(1) << PROD_LIM_EXP;
  localparam logic signed [RW-1:0] LIM_POS   = RW'(1) << PROD_LIM_EXP;
  localparam logic signed [RW-1:0] LIM_NEG   = -LIM_POS;

  logic                    neg;
  logic [C_WIDTH-1:0]      cmag;
  logic [C_WIDTH:0]        hi;
  logic [A_WIDTH-1:0]      lo;
  logic [CNT_W-1:0]        step;
  logic                    run;
  logic                    fin;
  logic [C_WIDTH:0]        sum;
  logic [PW-1:0]           prod;
  logic [QXW-1:0]          qx;
  logic [RW-1:0]           qr;
  logic                    rem_nz;
  logic                    clamp;
  logic signed [RW-1:0]    res_next;

  // Add the coefficient when the current multiplier bit is set
  assign sum = lo[0] ? hi + {1'b0, cmag} : hi;

  // Floor-shift the magnitude product, clamp, then apply the sign
  always_comb begin
    prod   = {hi[C_WIDTH-1:0], lo};
    qx     = QXW'(prod[PW-1:FRAC_BITS]);
    rem_nz = |prod[FRAC_BITS-1:0];
    clamp  = (qx >= LIM_X);
    qr     = qx[RW-1:0];
    if (clamp) begin
      res_next = neg ? LIM_NEG : LIM_POS;
    end else if (neg) begin
      res_next = rem_nz ? $signed(~qr) : $signed(-qr);
    end else begin
      res_next = $signed(qr);
    end
  end

  // Sequence: load, one bit per cycle, then a finishing step that registers the product and raises done
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= '0;
      end else if (run) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end

  // Shift-and-add datapath on magnitudes
  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= a[A_WIDTH-1] ^ c[C_WIDTH-1];
      cmag <= c[C_WIDTH-1] ? C_WIDTH'(-c) : C_WIDTH'(c);
      hi   <= '0;
      lo   <= a[A_WIDTH-1] ? A_WIDTH'(-a) : A_WIDTH'(a);
    end else if (run) begin
      hi <= {1'b0, sum[C_WIDTH:1]};
      lo <= {sum[0], lo[A_WIDTH-1:1]};
    end
    if (fin) begin
      product <= res_next;
    end
  end

endmodule

// ----- rtl/core/pll_pi_lowpass_integrator.sv -----
// Phase-locked loop: Tustin PI, first-order low-pass and trapezoidal angle integrator.
// Takes one reference beat at a time: reference.ready stays low from acceptance until the
// result beat is handed off. Each beat makes two dependent passes through bit-serial
// multipliers that take one operand bit a cycle.
// Reset (rst, synchronous): loop state cleared to zero, coefficients to their defaults.
module pll_pi_lowpass_integrator #(
  parameter int DATA_WIDTH     = pllpi_pkg::DEF_DATA_WIDTH,
  parameter int COEF_FRAC_BITS = pllpi_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  pllpi_ref_if.sink                            reference,
  pllpi_est_if.source                          estimate,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pllpi_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [pllpi_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [pllpi_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                                 pready
);
  import pllpi_pkg::*;

  localparam int AW   = DATA_WIDTH + 1;
  localparam int RW   = MUL_RES_WIDTH;
  localparam int SUMW = RW + 2;
  localparam int DFW  = ((DATA_WIDTH > FIELD_WIDTH) ? DATA_WIDTH : FIELD_WIDTH) + 1;
  localparam int OXW  = (DATA_WIDTH > FIELD_WIDTH) ? DATA_WIDTH : FIELD_WIDTH;

  localparam logic signed [DATA_WIDTH-1:0]  D_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0]  D_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [FIELD_WIDTH-1:0] F_MAX = {1'b0, {(FIELD_WIDTH-1){1'b1}}};
  localparam logic signed [FIELD_WIDTH-1:0] F_MIN = {1'b1, {(FIELD_WIDTH-1){1'b0}}};

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START1 = 3'd1;
  localparam logic [2:0] S_MUL1   = 3'd2;
  localparam logic [2:0] S_START2 = 3'd3;
  localparam logic [2:0] S_MUL2   = 3'd4;
  localparam logic [2:0] S_PUSH   = 3'd5;

  // Clip a wide sum to the data width
  function automatic logic signed [DATA_WIDTH-1:0] sat_sum(input logic signed [SUMW-1:0] x);
    logic hit;
    hit = (x[SUMW-1:DATA_WIDTH-1] != {(SUMW-DATA_WIDTH+1){x[SUMW-1]}});
    if (hit) return x[SUMW-1] ? D_MIN : D_MAX;
    return x[DATA_WIDTH-1:0];
  endfunction

  // Clip a state value to the output field
  function automatic logic signed [FIELD_WIDTH-1:0] sat_field(
    input logic signed [DATA_WIDTH-1:0] v
  );
    logic signed [OXW-1:0] ext;
    logic                  hit;
    ext = OXW'(v);
    hit = (ext[OXW-1:FIELD_WIDTH-1] != {(OXW-FIELD_WIDTH+1){ext[OXW-1]}});
    if (hit) return ext[OXW-1] ? F_MIN : F_MAX;
    return ext[FIELD_WIDTH-1:0];
  endfunction

  pllpi_coef_t coef;

  logic [2:0]                   state;
  logic signed [DATA_WIDTH-1:0] err_r;
  logic signed [DATA_WIDTH-1:0] pi_r;
  logic signed [DATA_WIDTH-1:0] prev_error;
  logic signed [DATA_WIDTH-1:0] prev_pi_output;
  logic signed [DATA_WIDTH-1:0] speed_reg;
  logic signed [DATA_WIDTH-1:0] angle_reg;
  logic                         out_valid;
  logic signed [FIELD_WIDTH-1:0] speed_out;
  logic signed [FIELD_WIDTH-1:0] angle_out;

  logic signed [DFW-1:0]         diff;
  logic signed [DATA_WIDTH-1:0]  err_next;
  logic signed [AW-1:0]          pair;
  logic                          phase1;
  logic                          start1;
  logic                          start_any;
  logic signed [AW-1:0]          a0;
  logic signed [AW-1:0]          a1;
  logic signed [COEF_WIDTH-1:0]  c0;
  logic signed [COEF_WIDTH-1:0]  c1;
  logic                          done0;
  logic                          done1;
  logic                          done2;
  logic                          mul_done;
  logic signed [RW-1:0]          m0;
  logic signed [RW-1:0]          m1;
  logic signed [RW-1:0]          m2;
  logic signed [SUMW-1:0]        pi_sum;
  logic signed [SUMW-1:0]        spd_sum;
  logic signed [SUMW-1:0]        ang_sum;
  logic                          can_push;

  pllpi_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef    (coef)
  );

  // Error against the previous angle estimate
  always_comb begin
    diff = DFW'(reference.reference_angle) - DFW'(angle_reg);
    if (diff[DFW-1:DATA_WIDTH-1] != {(DFW-DATA_WIDTH+1){diff[DFW-1]}}) begin
      err_next = diff[DFW-1] ? D_MIN : D_MAX;
    end else begin
      err_next = diff[DATA_WIDTH-1:0];
    end
  end

  // Operand selection for the two passes
  assign phase1    = (state == S_START1);
  assign start1    = phase1;
  assign start_any = phase1 | (state == S_START2);
  assign pair      = AW'(pi_r) + AW'(prev_pi_output);
  assign a0        = phase1 ? AW'(err_r) : pair;
  assign a1        = phase1 ? AW'(prev_error) : pair;
  assign c0        = phase1 ? coef.pi_gain_now : coef.lowpass_feed;
  assign c1        = phase1 ? coef.pi_gain_last : coef.half_period;
  assign mul_done  = done0 & done1;

  pllpi_serial_mul #(
    .A_WIDTH   (AW),
    .C_WIDTH   (COEF_WIDTH),
    .FRAC_BITS (COEF_FRAC_BITS)
  ) u_mul0 (
    .clk     (clk),
    .rst     (rst),
    .start   (start_any),
    .a       (a0),
    .c       (c0),
    .done    (done0),
    .product (m0)
  );

  pllpi_serial_mul #(
    .A_WIDTH   (AW),
    .C_WIDTH   (COEF_WIDTH),
    .FRAC_BITS (COEF_FRAC_BITS)
  ) u_mul1 (
    .clk     (clk),
    .rst     (rst),
    .start   (start_any),
    .a       (a1),
    .c       (c1),
    .done    (done1),
    .product (m1)
  );

  // Low-pass feedback term runs alongside the PI products
  pllpi_serial_mul #(
    .A_WIDTH   (AW),
    .C_WIDTH   (COEF_WIDTH),
    .FRAC_BITS (COEF_FRAC_BITS)
  ) u_mul2 (
    .clk     (clk),
    .rst     (rst),
    .start   (start1),
    .a       (AW'(speed_reg)),
    .c       (coef.lowpass_feedback),
    .done    (done2),
    .product (m2)
  );

  assign pi_sum   = SUMW'(prev_pi_output) + SUMW'(m0) + SUMW'(m1);
  assign spd_sum  = SUMW'(m0) + SUMW'(m2);
  assign ang_sum  = SUMW'(angle_reg) + SUMW'(m1);
  assign can_push = ~out_valid | estimate.ready;

  assign reference.ready         = (state == S_IDLE);
  assign estimate.valid          = out_valid;
  assign estimate.speed_estimate = speed_out;
  assign estimate.angle_estimate = angle_out;

  // Sequencer: error, PI pass, filter and integrator pass, hand-off
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      prev_error     <= '0;
      prev_pi_output <= '0;
      speed_reg      <= '0;
      angle_reg      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (reference.valid) state <= S_START1;
        end
        S_START1: state <= S_MUL1;
        S_MUL1: begin
          if (mul_done && done2) state <= S_START2;
        end
        S_START2: state <= S_MUL2;
        S_MUL2: begin
          if (mul_done) begin
            prev_error     <= err_r;
            prev_pi_output <= pi_r;
            speed_reg      <= sat_sum(spd_sum);
            angle_reg      <= sat_sum(ang_sum);
            state          <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (can_push) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Hold the working values of the current beat
  always_ff @(posedge clk) begin
    if (state == S_IDLE && reference.valid) err_r <= err_next;
    if (state == S_MUL1 && mul_done && done2) pi_r <= sat_sum(pi_sum);
  end

  // Output register: load on hand-off, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_PUSH && can_push) begin
      out_valid <= 1'b1;
    end else if (estimate.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PUSH && can_push) begin
      speed_out <= sat_field(speed_reg);
      angle_out <= sat_field(angle_reg);
    end
  end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pllpi_pkg::*;

  // Run shape
  localparam int LATENCY         = 2 * DEF_DATA_WIDTH + 9;
  localparam int CYCLE_LIMIT     = 800000;
  localparam int IDLE_PCT        = 14;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int NUM_REGS        = 5;
  localparam int NUM_PHASES      = 8;
  localparam int PHASE_BEATS     = 230;
  localparam int STEADY_PHASE    = 3;
  localparam int PRESSURE_PHASE  = 5;
  localparam int PRESSURE_BEAT   = 40;
  localparam int REPORT_CAP      = 50;
  localparam int DIRECTED_ROWS   = 30;

  // Unmapped register slots inside the address window
  localparam logic [REG_INDEX_WIDTH-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [COEF_WIDTH-1:0] GAIN_MAX = 32'h7FFF_FFFF;
  localparam logic [COEF_WIDTH-1:0] GAIN_MIN = 32'h8000_0000;

  localparam longint DATA_MAX   = (longint'(1) <<< (DEF_DATA_WIDTH - 1)) - 1;
  localparam longint DATA_MIN   = -DATA_MAX - 1;
  localparam longint PROD_CLAMP = longint'(1) <<< PROD_LIM_EXP;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] speed;
    logic signed [FIELD_WIDTH-1:0] angle;
  } estimate_t;

  typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e                  kind;
    logic [REG_INDEX_WIDTH-1:0] index;
    logic [31:0]                value;
    logic                       pinned;
    logic [31:0]                want_speed;
    logic [31:0]                want_angle;
  } directed_row_t;

  typedef enum logic [2:0] {
    GAINS_DEFAULT, GAINS_MIXED, GAINS_MAX, GAINS_MIN, GAINS_ZERO
  } gain_style_e;

  logic                      clk     = 1'b0;
  logic                      rst     = 1'b1;
  logic                      psel    = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite  = 1'b0;
  logic [APB_ADDR_WIDTH-1:0] paddr   = '0;
  logic [APB_DATA_WIDTH-1:0] pwdata  = '0;
  logic [APB_DATA_WIDTH-1:0] prdata;
  logic                      pready;

  pllpi_ref_if reference_ch ();
  pllpi_est_if estimate_ch ();

  pll_pi_lowpass_integrator DUT (
    .clk       (clk),
    .rst       (rst),
    .reference (reference_ch),
    .estimate  (estimate_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Loop model state and its copy of the coefficients
  logic signed [COEF_WIDTH-1:0] default_gains [NUM_REGS] = '{
    RST_PI_GAIN_NOW, RST_PI_GAIN_LAST, RST_LOWPASS_FEED, RST_LOWPASS_FEEDBACK, RST_HALF_PERIOD
  };
  logic signed [COEF_WIDTH-1:0]     gain_shadow [NUM_REGS];
  logic signed [DEF_DATA_WIDTH-1:0] held_error = '0;
  logic signed [DEF_DATA_WIDTH-1:0] held_pi    = '0;
  logic signed [DEF_DATA_WIDTH-1:0] held_speed = '0;
  logic signed [DEF_DATA_WIDTH-1:0] held_angle = '0;

  estimate_t expected_estimates [$];

  int unsigned cycle_count   = 0;
  int          mismatches    = 0;
  int          beats_sent    = 0;
  int          beats_seen    = 0;
  int          writes_done   = 0;
  int          settings_used = 0;
  bit          steady        = 1'b0;
  int          hold_asked    = 0;
  int          hold_served   = 0;
  int          hold_left     = 0;

  // Directed rows: extremes, spare slots, saturating coefficients
  directed_row_t script [DIRECTED_ROWS] = '{
    '{ROW_BEAT,  '0,                   32'h0000_0000, 1'b1, 32'h0, 32'h0},
    '{ROW_BEAT,  '0,                   32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0},
    '{ROW_BEAT,  '0,                   32'h8000_0000, 1'b0, 32'h0, 32'h0},
    '{ROW_BEAT,  '0,                   32'h8000_0000, 1'b0, 32'h0, 32'h0},
    '{ROW_BEAT,  '0,                   32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0},
    '{ROW_BEAT,  '0,                   32'h0000_0000, 1'b0, 32'h0, 32'h0},
    '{ROW_BEAT,  '0,                   32'h0000_0001, 1'b0, 32'h0, 32'h0},
    '{ROW_BEAT,  '0,                   32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
    '{ROW_BEAT,  '0,                   32'h0001_0000, 1'b0, 32'h0, 32'h0},
    '{ROW_WRITE, REG_SPARE_LO,         32'h0000_0000, 1'b0, 32'h0, 32'h0},
    '{ROW_WRITE, REG_SPARE_HI,         32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
    '{ROW_BEAT,  '0,                   32'h0003_0000, 1'b0, 32'h0, 32'h0},
    '{ROW_WRITE, REG_PI_GAIN_NOW,      GAIN_MAX,      1'b0, 32'h0, 32'h0},
    '{ROW_WRITE, REG_PI_GAIN_LAST,     GAIN_MIN,      1'b0, 32'h0, 32'h0},
    '{ROW_WRITE, REG_LOWPASS_FEED,     GAIN_MAX,      1'b0, 32'h0, 32'h0},
    '{ROW_WRITE, REG_LOWPASS_FEEDBACK, GAIN_MAX,      1'b0, 32'h0, 32'h0},
    '{ROW_WRITE, REG_HALF_PERIOD,      GAIN_MIN,      1'b0, 32'h0, 32'h0},
    '{ROW_BEAT,  '0,                   32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0},
    '{ROW_BEAT,  '0,                   32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0},
    '{ROW_BEAT,  '0,                   32'h8000_0000, 1'b0, 32'h0, 32'h0},
    '{ROW_BEAT,  '0,                   32'h8000_0000, 1'b0, 32'h0, 32'h0},
    '{ROW_BEAT,  '0,                   32'h1234_5678, 1'b0, 32'h0, 32'h0},
    '{ROW_WRITE, REG_PI_GAIN_NOW,      GAIN_MIN,      1'b0, 32'h0, 32'h0},
    '{ROW_WRITE, REG_PI_GAIN_LAST,     GAIN_MAX,      1'b0, 32'h0, 32'h0},
    '{ROW_WRITE, REG_LOWPASS_FEED,     GAIN_MIN,      1'b0, 32'h0, 32'h0},
    '{ROW_WRITE, REG_LOWPASS_FEEDBACK, GAIN_MIN,      1'b0, 32'h0, 32'h0},
    '{ROW_WRITE, REG_HALF_PERIOD,      GAIN_MAX,      1'b0, 32'h0, 32'h0},
    '{ROW_BEAT,  '0,                   32'h8000_0000, 1'b0, 32'h0, 32'h0},
    '{ROW_BEAT,  '0,                   32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0},
    '{ROW_BEAT,  '0,                   32'h0000_0000, 1'b0, 32'h0, 32'h0}
  };

  gain_style_e phase_plan [NUM_PHASES] = '{
    GAINS_DEFAULT, GAINS_MIXED, GAINS_MAX, GAINS_MIXED,
    GAINS_MIN, GAINS_MIXED, GAINS_ZERO, GAINS_DEFAULT
  };

  // Clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Drive every input to a known value from time zero
  initial begin
    reference_ch.valid           = 1'b0;
    reference_ch.reference_angle = '0;
    estimate_ch.ready            = 1'b0;
    gain_shadow                  = default_gains;
  end

  task automatic report_mismatch(input string detail);
    if (mismatches < REPORT_CAP)
      $display("mismatch at cycle %0d: %s", cycle_count, detail);
    mismatches++;
  endtask

  // Clamp to the signed data width
  function automatic longint sat_data(input longint x);
    if (x > DATA_MAX) return DATA_MAX;
    if (x < DATA_MIN) return DATA_MIN;
    return x;
  endfunction

  // Exact product, floored by the coefficient fraction, clamped
  function automatic longint coef_product(input longint data, input longint coef);
    logic signed [127:0] wide_data, wide_coef, wide_prod;
    wide_data = data;
    wide_coef = coef;
    wide_prod = (wide_data * wide_coef) >>> DEF_COEF_FRAC_BITS;
    if (wide_prod > PROD_CLAMP) return PROD_CLAMP;
    if (wide_prod < -PROD_CLAMP) return -PROD_CLAMP;
    return longint'(wide_prod);
  endfunction

  // Advance the loop model by one reference sample
  task automatic advance_loop_model(input logic signed [FIELD_WIDTH-1:0] sample,
                                    output estimate_t est);
    longint err, pi_out, pair, spd, ang;
    err    = sat_data(longint'(sample) - longint'(held_angle));
    pi_out = sat_data(longint'(held_pi)
                      + coef_product(err, gain_shadow[REG_PI_GAIN_NOW])
                      + coef_product(held_error, gain_shadow[REG_PI_GAIN_LAST]));
    pair   = pi_out + longint'(held_pi);
    spd    = sat_data(coef_product(pair, gain_shadow[REG_LOWPASS_FEED])
                      + coef_product(held_speed, gain_shadow[REG_LOWPASS_FEEDBACK]));
    ang    = sat_data(longint'(held_angle) + coef_product(pair, gain_shadow[REG_HALF_PERIOD]));
    held_error = err[DEF_DATA_WIDTH-1:0];
    held_pi    = pi_out[DEF_DATA_WIDTH-1:0];
    held_speed = spd[DEF_DATA_WIDTH-1:0];
    held_angle = ang[DEF_DATA_WIDTH-1:0];
    est.speed  = spd[FIELD_WIDTH-1:0];
    est.angle  = ang[FIELD_WIDTH-1:0];
  endtask

  // Offer one reference beat; valid stays high after acceptance
  task automatic offer_reference(input logic [FIELD_WIDTH-1:0] sample, input bit pinned_valid,
                                 input estimate_t pinned);
    estimate_t predicted;
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      reference_ch.valid <= 1'b0;
      @(negedge clk);
    end
    reference_ch.valid           <= 1'b1;
    reference_ch.reference_angle <= sample;
    do @(posedge clk); while (!reference_ch.ready);
    advance_loop_model(sample, predicted);
    expected_estimates.push_back(pinned_valid ? pinned : predicted);
    beats_sent++;
  endtask

  // Drop valid and wait for every pending estimate
  task automatic settle_loop();
    @(negedge clk);
    reference_ch.valid <= 1'b0;
    while (expected_estimates.size() != 0) @(posedge clk);
  endtask

  // Write one register, then read it back where it is mapped
  task automatic write_register(input logic [REG_INDEX_WIDTH-1:0] index,
                                input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (index < NUM_REGS) gain_shadow[index] = value;
    writes_done++;
    @(negedge clk);
    penable <= 1'b0;
    if (index < NUM_REGS) begin
      pwrite <= 1'b0;
      @(negedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (prdata !== gain_shadow[index])
        report_mismatch($sformatf("register %0d reads %h, wrote %h", index, prdata,
                                  gain_shadow[index]));
      @(negedge clk);
      penable <= 1'b0;
    end
    psel <= 1'b0;
  endtask

  function automatic logic [31:0] pick_gain(input gain_style_e style, input int r);
    case (style)
      GAINS_DEFAULT: return default_gains[r];
      GAINS_MAX:     return GAIN_MAX;
      GAINS_MIN:     return GAIN_MIN;
      GAINS_ZERO:    return '0;
      default: begin
        case ($urandom_range(2))
          0:       return $urandom;
          1:       return default_gains[r] + ($signed($urandom_range(2 ** 21)) - 2 ** 20);
          default: return $urandom_range(1) ? GAIN_MAX : GAIN_MIN;
        endcase
      end
    endcase
  endfunction

  // Random references: mostly ramps with jitter, some jumps and raw noise
  task automatic run_random_phase(input int beats, input int hold_at);
    logic signed [FIELD_WIDTH-1:0] ramp, slope, sample;
    int left, mode;
    ramp  = $urandom;
    slope = '0;
    left  = 0;
    mode  = 0;
    for (int n = 0; n < beats; n++) begin
      if (left == 0) begin
        left  = $urandom_range(60, 10);
        mode  = $urandom_range(99);
        slope = $signed($urandom_range(65536)) - 32768;
        if (mode < 20) ramp = $urandom;
      end
      left--;
      ramp = ramp + slope;
      if (mode < 15) sample = $urandom;
      else sample = ramp + ($signed($urandom_range(64)) - 32);
      if (n == hold_at) hold_asked++;
      offer_reference(sample, 1'b0, '0);
    end
    settle_loop();
  endtask

  // Cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d estimates pending", cycle_count,
               expected_estimates.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Estimate sink: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_asked != hold_served) begin
      hold_served = hold_asked;
      hold_left   = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      estimate_ch.ready <= 1'b0;
    end else begin
      estimate_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compare each estimate beat with the oldest pending one
  always @(posedge clk) begin : check_estimates
    estimate_t oldest;
    if (!rst && estimate_ch.valid && estimate_ch.ready) begin
      beats_seen++;
      if (expected_estimates.size() == 0) begin
        report_mismatch($sformatf("estimate beat with none pending: speed %h angle %h",
                                  estimate_ch.speed_estimate, estimate_ch.angle_estimate));
      end else begin
        oldest = expected_estimates.pop_front();
        if (estimate_ch.speed_estimate !== oldest.speed)
          report_mismatch($sformatf("beat %0d speed %h, want %h", beats_seen,
                                    estimate_ch.speed_estimate, oldest.speed));
        if (estimate_ch.angle_estimate !== oldest.angle)
          report_mismatch($sformatf("beat %0d angle %h, want %h", beats_seen,
                                    estimate_ch.angle_estimate, oldest.angle));
      end
    end
  end

  initial begin : stimulus
    estimate_t pinned;
    // Hold reset, then release it on a falling clock edge
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed rows
    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        settle_loop();
        write_register(script[i].index, script[i].value);
      end else begin
        pinned.speed = script[i].want_speed;
        pinned.angle = script[i].want_angle;
        offer_reference(script[i].value, script[i].pinned, pinned);
      end
    end
    settle_loop();

    // Random phases, each under its own coefficient setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      for (int r = 0; r < NUM_REGS; r++)
        write_register(REG_INDEX_WIDTH'(r), pick_gain(phase_plan[p], r));
      settings_used++;
      steady = (p == STEADY_PHASE);
      run_random_phase(PHASE_BEATS, (p == PRESSURE_PHASE) ? PRESSURE_BEAT : -1);
    end
    steady = 1'b0;

    // Drain, then give the block time to show any stray beat
    settle_loop();
    repeat (LATENCY + 8) @(posedge clk);

    $display("covered %0d reference beats, %0d estimate beats, %0d register writes",
             beats_sent, beats_seen, writes_done);
    $display("over %0d random coefficient settings plus saturating directed cases",
             settings_used);
    if (mismatches == 0 && expected_estimates.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
